// ===== rtl/perspective_point_projector_top_assert.svh =====
// Assertion macros used by the projector RTL.
`ifndef PERSPECTIVE_POINT_PROJECTOR_TOP_ASSERT_SVH
`define PERSPECTIVE_POINT_PROJECTOR_TOP_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define PPP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define PPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ppp_pkg.sv =====
package ppp_pkg;

    localparam int COEF_CNT   = 12;
    localparam int COEF_IDX_W = 4;
    localparam int DATA_W     = 32;
    localparam int COORD_W    = 33;
    localparam int PROD_W     = 65;
    localparam int FRAC_W     = 16;
    localparam int ACC_W      = 51;
    localparam int QUO_W      = 40;
    localparam int DVD_W      = 80;
    localparam int CHUNK_W    = 31;
    localparam int DIM_W      = 14;
    localparam int HALF_SHIFT = 15;
    localparam int HALF_W     = DIM_W + HALF_SHIFT;
    localparam int DEPTH_W    = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int OUT_SUM_W  = 43;

    localparam logic [DIM_W-1:0]          WIDTH_RST  = 14'd1920;
    localparam logic [DIM_W-1:0]          HEIGHT_RST = 14'd1080;
    localparam logic [DEPTH_W-1:0]        DEPTH_RST  = 31'd655;
    localparam logic signed [COORD_W-1:0] ROW_ONE    = 33'sd65536;
    localparam logic [COEF_IDX_W-1:0]     COEF_LAST  = 4'd11;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_PROJ = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_MIN_DEPTH     = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        SC_X_LO = 2'd0,
        SC_X_HI = 2'd1,
        SC_Y_LO = 2'd2,
        SC_Y_HI = 2'd3
    } t_sc_step;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_CHECK,
        ST_SCALE,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/ppp_item_if.sv =====
interface ppp_item_if;
    logic                               valid;
    logic                               ready;
    logic                               op;
    logic [ppp_pkg::COEF_IDX_W-1:0]     coef_index;
    logic signed [ppp_pkg::DATA_W-1:0]  coef_value;
    logic signed [ppp_pkg::DATA_W-1:0]  pos_x;
    logic signed [ppp_pkg::DATA_W-1:0]  pos_y;
    logic signed [ppp_pkg::DATA_W-1:0]  pos_z;
    logic signed [ppp_pkg::DATA_W-1:0]  z_rise;

    modport source (
        output valid, op, coef_index, coef_value, pos_x, pos_y, pos_z, z_rise,
        input  ready
    );
    modport sink (
        input  valid, op, coef_index, coef_value, pos_x, pos_y, pos_z, z_rise,
        output ready
    );
endinterface

// ===== rtl/ppp_res_if.sv =====
interface ppp_res_if;
    logic                               valid;
    logic                               ready;
    logic                               visible;
    logic signed [ppp_pkg::DATA_W-1:0]  screen_x;
    logic signed [ppp_pkg::DATA_W-1:0]  screen_y;

    modport source (
        output valid, visible, screen_x, screen_y,
        input  ready
    );
    modport sink (
        input  valid, visible, screen_x, screen_y,
        output ready
    );
endinterface

// ===== rtl/ppp_div.sv =====
module ppp_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ppp_pkg::DVD_W-1:0]     i_dividend,
    input  logic [ppp_pkg::ACC_W-1:0]     i_divisor,
    output logic                          o_done,
    output logic [ppp_pkg::QUO_W:0]       o_quot
);

    localparam int CNT_W = $clog2(ppp_pkg::QUO_W);
    localparam int HI_W  = ppp_pkg::DVD_W - ppp_pkg::QUO_W;

    logic                         r_busy;
    logic                         r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [ppp_pkg::ACC_W-1:0]    r_rem;
    logic [ppp_pkg::ACC_W-1:0]    r_dvs;
    logic [ppp_pkg::QUO_W-1:0]    r_low;
    logic [ppp_pkg::QUO_W-1:0]    r_quo;
    logic                         r_big;

    logic [ppp_pkg::ACC_W:0]      w_trial;
    logic [ppp_pkg::ACC_W:0]      w_diff;
    logic                         w_ge;
    logic                         w_big;
    logic                         w_last;

    assign w_trial = {r_rem, r_low[ppp_pkg::QUO_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_last  = r_cnt == CNT_W'(ppp_pkg::QUO_W - 1);
    assign w_big   = {{(ppp_pkg::ACC_W - HI_W){1'b0}},
                      i_dividend[ppp_pkg::DVD_W-1:ppp_pkg::QUO_W]} >= i_divisor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_big <= w_big;
            r_low <= i_dividend[ppp_pkg::QUO_W-1:0];
            r_quo <= '0;
            if (w_big) begin
                r_rem <= '0;
            end else begin
                r_rem <= {{(ppp_pkg::ACC_W - HI_W){1'b0}},
                          i_dividend[ppp_pkg::DVD_W-1:ppp_pkg::QUO_W]};
            end
        end else if (r_busy) begin
            r_low <= {r_low[ppp_pkg::QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[ppp_pkg::QUO_W-2:0], w_ge};
            if (w_ge) begin
                r_rem <= w_diff[ppp_pkg::ACC_W-1:0];
            end else begin
                r_rem <= w_trial[ppp_pkg::ACC_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_big ? {1'b1, {ppp_pkg::QUO_W{1'b0}}} : {1'b0, r_quo};

endmodule

// ===== rtl/perspective_point_projector_top.sv =====
// Load word: accepted one per cycle while idle.
// Project word: the dot products, the visibility check and, for a visible point only, the
// scaling and the divide run in turn; the next word is taken once the result is registered.
// Coefficient memory is read once per cycle through one port, and the two
// restoring dividers retire one quotient bit per cycle.
// Synchronous active-low reset: coefficients read as zero, control and config registers return to defaults.
`include "perspective_point_projector_top_assert.svh"

module perspective_point_projector_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ppp_item_if.sink                          i_item,
    ppp_res_if.source                         o_res,
    input  logic                              i_cfg_we,
    input  logic [ppp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ppp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW = ppp_pkg::ACC_W;
    localparam int QW = ppp_pkg::QUO_W;
    localparam int SW = ppp_pkg::OUT_SUM_W;

    function automatic logic [ppp_pkg::DATA_W-1:0] sat32(input logic signed [SW-1:0] v);
        logic [ppp_pkg::DATA_W-1:0] res;
        if (v > $signed({{(SW - ppp_pkg::DATA_W + 1){1'b0}}, {(ppp_pkg::DATA_W - 1){1'b1}}})) begin
            res = {1'b0, {(ppp_pkg::DATA_W - 1){1'b1}}};
        end else if (v < $signed({{(SW - ppp_pkg::DATA_W + 1){1'b1}},
                                  {(ppp_pkg::DATA_W - 1){1'b0}}})) begin
            res = {1'b1, {(ppp_pkg::DATA_W - 1){1'b0}}};
        end else begin
            res = v[ppp_pkg::DATA_W-1:0];
        end
        return res;
    endfunction

    ppp_pkg::t_state r_state;
    ppp_pkg::t_state n_state;

    logic [ppp_pkg::DIM_W-1:0]     r_width;
    logic [ppp_pkg::DIM_W-1:0]     r_height;
    logic [ppp_pkg::DEPTH_W-1:0]   r_min_depth;

    logic [ppp_pkg::DATA_W-1:0]    mem [0:ppp_pkg::COEF_CNT-1];
    logic [ppp_pkg::COEF_CNT-1:0]  r_cvld;
    logic [ppp_pkg::DATA_W-1:0]    r_rdata;
    logic                          r_rvld;

    logic [ppp_pkg::COEF_IDX_W-1:0] r_cnt;
    logic                           r_iss_end;
    logic                           r_s1_vld;
    logic [ppp_pkg::COEF_IDX_W-1:0] r_s1_idx;
    logic                           r_s2_vld;
    logic [ppp_pkg::COEF_IDX_W-1:0] r_s2_idx;
    logic                           r_k_vld;
    logic [1:0]                     r_k_step;

    logic signed [ppp_pkg::DATA_W-1:0]  r_px;
    logic signed [ppp_pkg::DATA_W-1:0]  r_py;
    logic signed [ppp_pkg::DATA_W-1:0]  r_pz;
    logic signed [ppp_pkg::COORD_W-1:0] r_pzr;

    logic signed [ppp_pkg::PROD_W-1:0] r_prod;
    logic signed [AW-1:0]              r_acc_x;
    logic signed [AW-1:0]              r_acc_y;
    logic signed [AW-1:0]              r_acc_w;
    logic [ppp_pkg::DVD_W-1:0]         r_dvd_x;
    logic [ppp_pkg::DVD_W-1:0]         r_dvd_y;
    logic                              r_vis;
    logic                              r_div_start;

    logic                              r_ovld;
    logic                              r_ovis;
    logic [ppp_pkg::DATA_W-1:0]        r_osx;
    logic [ppp_pkg::DATA_W-1:0]        r_osy;

    logic                              w_accept;
    logic                              w_load_we;
    logic                              w_proj;
    logic                              w_mac_iss;
    logic                              w_sc_iss;
    logic                              w_out_load;
    logic                              w_mac_end;
    logic                              w_sc_end;
    logic                              w_vis;
    logic signed [ppp_pkg::DATA_W-1:0] w_coef;
    logic signed [ppp_pkg::COORD_W-1:0] m_a;
    logic signed [ppp_pkg::DATA_W-1:0]  m_c;
    logic signed [ppp_pkg::PROD_W-1:0]  m_p;
    logic [ppp_pkg::HALF_W-1:0]        w_hw;
    logic [ppp_pkg::HALF_W-1:0]        w_hh;
    logic [AW-1:0]                     w_mag_x;
    logic [AW-1:0]                     w_mag_y;
    logic [AW-1:0]                     w_mag_sel;
    logic [ppp_pkg::CHUNK_W-1:0]       w_chunk;
    logic [AW-1:0]                     w_term;
    logic                              w_done_x;
    logic                              w_done_y;
    logic [QW:0]                       w_qx;
    logic [QW:0]                       w_qy;
    logic signed [SW-1:0]              w_tx;
    logic signed [SW-1:0]              w_ty;
    logic signed [SW-1:0]              w_sum_x;
    logic signed [SW-1:0]              w_sum_y;

    assign w_accept  = i_item.valid && i_item.ready;
    assign w_proj    = w_accept && (i_item.op == ppp_pkg::OP_PROJ);
    assign w_load_we = w_accept && (i_item.op == ppp_pkg::OP_LOAD)
                       && (i_item.coef_index <= ppp_pkg::COEF_LAST);
    assign w_mac_end = r_s2_vld && (r_s2_idx == ppp_pkg::COEF_LAST);
    assign w_sc_end  = r_k_vld && (r_k_step == ppp_pkg::SC_Y_HI);
    assign w_vis     = (r_acc_w != '0)
                       && (r_acc_w >= $signed({{(AW - ppp_pkg::DEPTH_W){1'b0}}, r_min_depth}));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= ppp_pkg::WIDTH_RST;
            r_height    <= ppp_pkg::HEIGHT_RST;
            r_min_depth <= ppp_pkg::DEPTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ppp_pkg::CFG_SCREEN_WIDTH:  r_width     <= i_cfg_data[ppp_pkg::DIM_W-1:0];
                ppp_pkg::CFG_SCREEN_HEIGHT: r_height    <= i_cfg_data[ppp_pkg::DIM_W-1:0];
                ppp_pkg::CFG_MIN_DEPTH:     r_min_depth <= i_cfg_data[ppp_pkg::DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    // coefficient memory
    always_ff @(posedge i_clk) begin
        if (w_load_we) begin
            mem[i_item.coef_index] <= i_item.coef_value;
        end
        r_rdata <= mem[r_cnt];
        r_rvld  <= r_cvld[r_cnt];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld <= '0;
        end else if (w_load_we) begin
            r_cvld[i_item.coef_index] <= 1'b1;
        end
    end

    assign w_coef = r_rvld ? $signed(r_rdata) : '0;

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ppp_pkg::ST_IDLE: begin
                if (w_proj) begin
                    n_state = ppp_pkg::ST_MAC;
                end
            end
            ppp_pkg::ST_MAC: begin
                if (w_mac_end) begin
                    n_state = ppp_pkg::ST_CHECK;
                end
            end
            ppp_pkg::ST_CHECK: begin
                n_state = w_vis ? ppp_pkg::ST_SCALE : ppp_pkg::ST_OUT;
            end
            ppp_pkg::ST_SCALE: begin
                if (w_sc_end) begin
                    n_state = ppp_pkg::ST_DIV;
                end
            end
            ppp_pkg::ST_DIV: begin
                if (w_done_x) begin
                    n_state = ppp_pkg::ST_OUT;
                end
            end
            ppp_pkg::ST_OUT: begin
                if (!r_ovld || o_res.ready) begin
                    n_state = ppp_pkg::ST_IDLE;
                end
            end
            default: n_state = ppp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        i_item.ready = 1'b0;
        w_mac_iss    = 1'b0;
        w_sc_iss     = 1'b0;
        w_out_load   = 1'b0;
        unique case (r_state)
            ppp_pkg::ST_IDLE:  i_item.ready = 1'b1;
            ppp_pkg::ST_MAC:   w_mac_iss    = !r_iss_end;
            ppp_pkg::ST_CHECK: ;
            ppp_pkg::ST_SCALE: w_sc_iss     = !r_iss_end;
            ppp_pkg::ST_DIV:   ;
            ppp_pkg::ST_OUT:   w_out_load   = !r_ovld || o_res.ready;
            default: ;
        endcase
    end

    // issue counter and stage tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_iss_end   <= 1'b0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_k_vld     <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_s1_vld    <= w_mac_iss;
            r_s2_vld    <= r_s1_vld;
            r_k_vld     <= w_sc_iss;
            r_div_start <= (r_state == ppp_pkg::ST_SCALE) && w_sc_end;
            if (r_state == ppp_pkg::ST_IDLE || r_state == ppp_pkg::ST_CHECK) begin
                r_iss_end <= 1'b0;
                r_cnt     <= '0;
            end else if (w_mac_iss) begin
                if (r_cnt == ppp_pkg::COEF_LAST) begin
                    r_cnt     <= '0;
                    r_iss_end <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end else if (w_sc_iss) begin
                if (r_cnt[1:0] == ppp_pkg::SC_Y_HI) begin
                    r_cnt     <= '0;
                    r_iss_end <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= r_cnt;
        r_s2_idx <= r_s1_idx;
        r_k_step <= r_cnt[1:0];
    end

    // point capture
    always_ff @(posedge i_clk) begin
        if (w_proj) begin
            r_px  <= i_item.pos_x;
            r_py  <= i_item.pos_y;
            r_pz  <= i_item.pos_z;
            r_pzr <= {i_item.pos_z[ppp_pkg::DATA_W-1], i_item.pos_z}
                     + {i_item.z_rise[ppp_pkg::DATA_W-1], i_item.z_rise};
        end
    end

    // shared multiplier
    assign w_hw = {r_width, {ppp_pkg::HALF_SHIFT{1'b0}}};
    assign w_hh = {r_height, {ppp_pkg::HALF_SHIFT{1'b0}}};
    assign w_mag_x = r_acc_x[AW-1] ? AW'(-r_acc_x) : r_acc_x;
    assign w_mag_y = r_acc_y[AW-1] ? AW'(-r_acc_y) : r_acc_y;
    assign w_mag_sel = r_cnt[1] ? w_mag_y : w_mag_x;
    assign w_chunk = r_cnt[0] ? {{(2 * ppp_pkg::CHUNK_W - AW){1'b0}},
                                 w_mag_sel[AW-1:ppp_pkg::CHUNK_W]}
                              : w_mag_sel[ppp_pkg::CHUNK_W-1:0];

    always_comb begin
        if (r_state == ppp_pkg::ST_SCALE) begin
            m_a = {{(ppp_pkg::COORD_W - ppp_pkg::HALF_W){1'b0}}, (r_cnt[1] ? w_hh : w_hw)};
            m_c = {1'b0, w_chunk};
        end else begin
            m_c = w_coef;
            case (r_s1_idx[1:0])
                2'd0: m_a = {r_px[ppp_pkg::DATA_W-1], r_px};
                2'd1: m_a = {r_py[ppp_pkg::DATA_W-1], r_py};
                2'd2: m_a = (r_s1_idx[3:2] == 2'd1) ? r_pzr : {r_pz[ppp_pkg::DATA_W-1], r_pz};
                default: m_a = ppp_pkg::ROW_ONE;
            endcase
        end
    end

    assign m_p = m_a * m_c;

    always_ff @(posedge i_clk) begin
        r_prod <= m_p;
    end

    // accumulate dot products
    assign w_term = {{(AW - ppp_pkg::PROD_W + ppp_pkg::FRAC_W){r_prod[ppp_pkg::PROD_W-1]}},
                     r_prod[ppp_pkg::PROD_W-1:ppp_pkg::FRAC_W]};

    always_ff @(posedge i_clk) begin
        if (w_proj) begin
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_acc_w <= '0;
        end else if (r_s2_vld) begin
            case (r_s2_idx[3:2])
                2'd0:    r_acc_x <= r_acc_x + w_term;
                2'd1:    r_acc_y <= r_acc_y + w_term;
                2'd2:    r_acc_w <= r_acc_w + w_term;
                default: ;
            endcase
        end
    end

    // scaled dividends
    always_ff @(posedge i_clk) begin
        if (r_state == ppp_pkg::ST_CHECK) begin
            r_vis <= w_vis;
        end
        if (r_k_vld) begin
            case (r_k_step)
                ppp_pkg::SC_X_LO: r_dvd_x <= {{(ppp_pkg::DVD_W - ppp_pkg::PROD_W){1'b0}}, r_prod};
                ppp_pkg::SC_X_HI: r_dvd_x <= r_dvd_x + {r_prod[ppp_pkg::DVD_W-ppp_pkg::CHUNK_W-1:0],
                                                        {ppp_pkg::CHUNK_W{1'b0}}};
                ppp_pkg::SC_Y_LO: r_dvd_y <= {{(ppp_pkg::DVD_W - ppp_pkg::PROD_W){1'b0}}, r_prod};
                default:          r_dvd_y <= r_dvd_y + {r_prod[ppp_pkg::DVD_W-ppp_pkg::CHUNK_W-1:0],
                                                        {ppp_pkg::CHUNK_W{1'b0}}};
            endcase
        end
    end

    ppp_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_dvd_x),
        .i_divisor  (r_acc_w),
        .o_done     (w_done_x),
        .o_quot     (w_qx)
    );

    ppp_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_dvd_y),
        .i_divisor  (r_acc_w),
        .o_done     (w_done_y),
        .o_quot     (w_qy)
    );

    // center offset and saturation
    always_comb begin
        w_tx = r_acc_x[AW-1] ? -$signed({{(SW - QW - 1){1'b0}}, w_qx})
                             : $signed({{(SW - QW - 1){1'b0}}, w_qx});
        w_ty = r_acc_y[AW-1] ? -$signed({{(SW - QW - 1){1'b0}}, w_qy})
                             : $signed({{(SW - QW - 1){1'b0}}, w_qy});
        w_sum_x = $signed({{(SW - ppp_pkg::HALF_W){1'b0}}, w_hw}) + w_tx;
        w_sum_y = $signed({{(SW - ppp_pkg::HALF_W){1'b0}}, w_hh}) - w_ty;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_out_load) begin
            r_ovld <= 1'b1;
        end else if (o_res.ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_ovis <= r_vis;
            r_osx  <= r_vis ? sat32(w_sum_x) : '0;
            r_osy  <= r_vis ? sat32(w_sum_y) : '0;
        end
    end

    assign o_res.valid    = r_ovld;
    assign o_res.visible  = r_ovis;
    assign o_res.screen_x = r_osx;
    assign o_res.screen_y = r_osy;

    `PPP_ASSERT_NEXT(a_proj_starts_mac, i_clk, i_rst_n, w_proj, r_state == ppp_pkg::ST_MAC, "project word did not start the dot products")
    `PPP_ASSERT_SAME(a_hidden_zero, i_clk, i_rst_n, o_res.valid && !o_res.visible, o_res.screen_x == 0 && o_res.screen_y == 0, "hidden point with nonzero coordinates")
    `PPP_ASSERT_SAME(a_div_lockstep, i_clk, i_rst_n, w_done_x || w_done_y, w_done_x && w_done_y, "divider lanes out of step")
    `PPP_ASSERT_SAME(a_start_in_div, i_clk, i_rst_n, r_div_start, r_state == ppp_pkg::ST_DIV, "divide started outside divide state")

endmodule
